@@ design/rtfe_pkg.sv @@
// rtfe_pkg: shared widths, character codes, types and helper functions
`default_nettype none

package rtfe_pkg;

	localparam int CODE_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int MAX_BYTES = 8;
	localparam int COUNT_W   = 4;
	localparam int BCD_W     = 20;
	localparam int DD_W      = BCD_W + CODE_W;
	localparam int DD_STEPS  = 4;

	// character codes
	localparam logic [BYTE_W-1:0] CH_BSL    = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_APOS   = 8'h27;
	localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
	localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;

	// class boundaries
	localparam logic [CODE_W-1:0] CTRL_LIMIT  = 16'd32;
	localparam logic [CODE_W-1:0] ASCII_LIMIT = 16'd127;
	localparam logic [CODE_W-1:0] BYTE_LIMIT  = 16'd255;

	localparam logic [COUNT_W-1:0] CNT_ONE  = 4'd1;
	localparam logic [COUNT_W-1:0] CNT_TWO  = 4'd2;
	localparam logic [COUNT_W-1:0] CNT_FOUR = 4'd4;

	typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] byte_arr_t;

	// double dabble working state: bcd digits over remaining binary bits
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [DD_W-1:0]   sh;
	} dd_t;

	// one escaped code unit, byte 0 goes out first
	typedef struct packed {
		byte_arr_t          bytes;
		logic [COUNT_W-1:0] count;
	} esc_item_t;

	// one double dabble step: adjust digits, then shift left
	function automatic logic [DD_W-1:0] dabble_step(input logic [DD_W-1:0] x);
		logic [DD_W-1:0] y;
		y = x;
		for (int d = 0; d < BCD_W / 4; d++) begin
			if (y[CODE_W + 4*d +: 4] >= 4'd5) begin
				y[CODE_W + 4*d +: 4] = y[CODE_W + 4*d +: 4] + 4'd3;
			end
		end
		return {y[DD_W-2:0], 1'b0};
	endfunction

	// four dabble steps, one pipeline stage worth
	function automatic logic [DD_W-1:0] dabble_group(input logic [DD_W-1:0] x);
		logic [DD_W-1:0] y;
		y = x;
		for (int k = 0; k < DD_STEPS; k++) begin
			y = dabble_step(y);
		end
		return y;
	endfunction

	// lowercase hex digit
	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
		logic [BYTE_W-1:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'h0, nib};
		end else begin
			r = 8'h57 + {4'h0, nib};
		end
		return r;
	endfunction

	// decimal digit from a bcd nibble
	function automatic logic [BYTE_W-1:0] dec_char(input logic [3:0] nib);
		return {4'h3, nib};
	endfunction

endpackage

`default_nettype wire

@@ design/rtfe_code_if.sv @@
// rtfe_code_if: valid/ready channel carrying one text code unit
`default_nettype none

interface rtfe_code_if;
	logic                         valid;
	logic                         ready;
	logic [rtfe_pkg::CODE_W-1:0]  code_unit;

	modport source (output valid, output code_unit, input ready);
	modport sink   (input valid, input code_unit, output ready);
endinterface

`default_nettype wire

@@ design/rtfe_byte_if.sv @@
// rtfe_byte_if: valid/ready channel carrying one escaped byte and its last flag
`default_nettype none

interface rtfe_byte_if;
	logic                         valid;
	logic                         ready;
	logic [rtfe_pkg::BYTE_W-1:0]  out_byte;
	logic                         last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

@@ design/rtf_text_escaper.sv @@
// rtf_text_escaper: pipelined escaping of text code units into escaped bytes
//
// channel   dir  payload                      handshake
// code      in   code_unit[15:0]              valid/ready
// escaped   out  out_byte[7:0], last          valid/ready
//
// Six pipeline stages (capture, four double dabble stages of four steps,
// byte assembly) feed an output register that sends 1 to 8 words per item.
// Every byte of an item takes one output word, so plain text flows at one word
// per cycle while escaped is ready; decimal escapes hold input while their bytes go out.
// arst_n clears every valid bit; payload registers are not reset.
// A stall on escaped with stage six full freezes all stages together, nothing is dropped.
`default_nettype none

module rtf_text_escaper (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rtfe_code_if.sink    code,
	rtfe_byte_if.source  escaped
);

	rtfe_pkg::dd_t       dd_s1, dd_s2, dd_s3, dd_s4, dd_s5;
	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	rtfe_pkg::esc_item_t item_s6;
	rtfe_pkg::esc_item_t item_d;
	logic                item_take;
	logic                adv;

	// whole pipeline moves when the last stage is free or being unloaded
	assign adv        = !v_s6 || item_take;
	assign code.ready = adv;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= code.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// payload stages: capture, then four groups of dabble steps
	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s1.code <= code.code_unit;
			dd_s1.sh   <= {{rtfe_pkg::BCD_W{1'b0}}, code.code_unit};
			dd_s2.code <= dd_s1.code;
			dd_s2.sh   <= rtfe_pkg::dabble_group(dd_s1.sh);
			dd_s3.code <= dd_s2.code;
			dd_s3.sh   <= rtfe_pkg::dabble_group(dd_s2.sh);
			dd_s4.code <= dd_s3.code;
			dd_s4.sh   <= rtfe_pkg::dabble_group(dd_s3.sh);
			dd_s5.code <= dd_s4.code;
			dd_s5.sh   <= rtfe_pkg::dabble_group(dd_s4.sh);
			item_s6    <= item_d;
		end
	end

	// byte assembly from the class of the code unit
	always_comb begin
		logic [rtfe_pkg::CODE_W-1:0] c;
		logic [rtfe_pkg::BCD_W-1:0]  bcd;
		c   = dd_s5.code;
		bcd = dd_s5.sh[rtfe_pkg::DD_W-1:rtfe_pkg::CODE_W];
		item_d.bytes = '0;
		item_d.count = rtfe_pkg::CNT_ONE;
		if (c == {8'h00, rtfe_pkg::CH_BSL} || c == {8'h00, rtfe_pkg::CH_LBRACE}
				|| c == {8'h00, rtfe_pkg::CH_RBRACE}) begin
			item_d.bytes[0] = rtfe_pkg::CH_BSL;
			item_d.bytes[1] = c[7:0];
			item_d.count    = rtfe_pkg::CNT_TWO;
		end else if (c < rtfe_pkg::CTRL_LIMIT
				|| (c > rtfe_pkg::ASCII_LIMIT && c <= rtfe_pkg::BYTE_LIMIT)) begin
			item_d.bytes[0] = rtfe_pkg::CH_BSL;
			item_d.bytes[1] = rtfe_pkg::CH_APOS;
			item_d.bytes[2] = rtfe_pkg::hex_char(c[7:4]);
			item_d.bytes[3] = rtfe_pkg::hex_char(c[3:0]);
			item_d.count    = rtfe_pkg::CNT_FOUR;
		end else if (c <= rtfe_pkg::ASCII_LIMIT) begin
			item_d.bytes[0] = c[7:0];
			item_d.count    = rtfe_pkg::CNT_ONE;
		end else begin
			// decimal form, value is at least 256 so three digits or more
			item_d.bytes[0] = rtfe_pkg::CH_BSL;
			item_d.bytes[1] = rtfe_pkg::CH_U;
			if (bcd[19:16] != 4'd0) begin
				item_d.bytes[2] = rtfe_pkg::dec_char(bcd[19:16]);
				item_d.bytes[3] = rtfe_pkg::dec_char(bcd[15:12]);
				item_d.bytes[4] = rtfe_pkg::dec_char(bcd[11:8]);
				item_d.bytes[5] = rtfe_pkg::dec_char(bcd[7:4]);
				item_d.bytes[6] = rtfe_pkg::dec_char(bcd[3:0]);
				item_d.bytes[7] = rtfe_pkg::CH_QMARK;
				item_d.count    = 4'd8;
			end else if (bcd[15:12] != 4'd0) begin
				item_d.bytes[2] = rtfe_pkg::dec_char(bcd[15:12]);
				item_d.bytes[3] = rtfe_pkg::dec_char(bcd[11:8]);
				item_d.bytes[4] = rtfe_pkg::dec_char(bcd[7:4]);
				item_d.bytes[5] = rtfe_pkg::dec_char(bcd[3:0]);
				item_d.bytes[6] = rtfe_pkg::CH_QMARK;
				item_d.count    = 4'd7;
			end else begin
				item_d.bytes[2] = rtfe_pkg::dec_char(bcd[11:8]);
				item_d.bytes[3] = rtfe_pkg::dec_char(bcd[7:4]);
				item_d.bytes[4] = rtfe_pkg::dec_char(bcd[3:0]);
				item_d.bytes[5] = rtfe_pkg::CH_QMARK;
				item_d.count    = 4'd6;
			end
		end
	end

	// output register and byte sequencing
	rtfe_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (v_s6),
		.item       (item_s6),
		.item_take  (item_take),
		.escaped    (escaped)
	);

endmodule

`default_nettype wire

@@ design/rtfe_serializer.sv @@
// rtfe_serializer: output register that sends an escaped item one byte per word
`default_nettype none

module rtfe_serializer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire rtfe_pkg::esc_item_t item,
	output logic                    item_take,
	rtfe_byte_if.source             escaped
);

	rtfe_pkg::byte_arr_t                bytes_q;
	logic [rtfe_pkg::COUNT_W-1:0]       count_q;
	logic                               valid_q;
	logic                               last_byte;
	logic                               word_taken;

	// handshake and reload decision
	assign last_byte  = (count_q == rtfe_pkg::CNT_ONE);
	assign word_taken = valid_q && escaped.ready;
	assign item_take  = item_valid && (!valid_q || (escaped.ready && last_byte));

	// byte shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else if (item_take) begin
			valid_q <= 1'b1;
			count_q <= item.count;
			bytes_q <= item.bytes;
		end else if (word_taken) begin
			if (last_byte) begin
				valid_q <= 1'b0;
			end else begin
				count_q <= count_q - rtfe_pkg::CNT_ONE;
				bytes_q <= bytes_q >> rtfe_pkg::BYTE_W;
			end
		end
	end

	// output word
	assign escaped.valid    = valid_q;
	assign escaped.out_byte = bytes_q[0];
	assign escaped.last     = last_byte;

endmodule

`default_nettype wire

@@ dv/rtf_text_escaper_chk.sv @@
`timescale 1ns / 1ps
// rtf_text_escaper_chk: escape predictor and in-order word scoreboard for both channels

module rtf_text_escaper_chk (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        code_valid,
	input  wire logic                        code_ready,
	input  wire logic [rtfe_pkg::CODE_W-1:0] code_unit,
	input  wire logic                        esc_valid,
	input  wire logic                        esc_ready,
	input  wire logic [rtfe_pkg::BYTE_W-1:0] out_byte,
	input  wire logic                        last,
	output int                               fails,
	output int                               pending,
	output int                               units,
	output int                               words,
	output int                               hex_units,
	output int                               dec_units
);

	localparam int REPORT_MAX = 10;
	localparam int CODE_W     = rtfe_pkg::CODE_W;
	localparam int BYTE_W     = rtfe_pkg::BYTE_W;

	// one expected escaped word
	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              fin;
	} esc_word_t;

	esc_word_t expected_words[$];

	initial begin
		fails     = 0;
		pending   = 0;
		units     = 0;
		words     = 0;
		hex_units = 0;
		dec_units = 0;
	end

	// lowercase hex digit of one nibble
	function automatic logic [BYTE_W-1:0] nibble_ascii(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + BYTE_W'(n);
		end
		return 8'h61 + BYTE_W'(n) - 8'd10;
	endfunction

	// work out the escaped bytes of one code unit and queue them
	task automatic queue_escape(input logic [CODE_W-1:0] c);
		logic [BYTE_W-1:0] seq[$];
		logic [BYTE_W-1:0] digs[$];
		int                v;
		esc_word_t         w;
		if (c == CODE_W'(rtfe_pkg::CH_BSL) || c == CODE_W'(rtfe_pkg::CH_LBRACE)
				|| c == CODE_W'(rtfe_pkg::CH_RBRACE)) begin
			seq.push_back(rtfe_pkg::CH_BSL);
			seq.push_back(c[BYTE_W-1:0]);
		end else if (c < rtfe_pkg::CTRL_LIMIT
				|| (c > rtfe_pkg::ASCII_LIMIT && c <= rtfe_pkg::BYTE_LIMIT)) begin
			seq.push_back(rtfe_pkg::CH_BSL);
			seq.push_back(rtfe_pkg::CH_APOS);
			seq.push_back(nibble_ascii(c[7:4]));
			seq.push_back(nibble_ascii(c[3:0]));
			hex_units++;
		end else if (c <= rtfe_pkg::ASCII_LIMIT) begin
			seq.push_back(c[BYTE_W-1:0]);
		end else begin
			// decimal form, most significant digit first
			v = int'(c);
			while (v != 0) begin
				digs.push_front(BYTE_W'(8'h30 + v % 10));
				v = v / 10;
			end
			seq.push_back(rtfe_pkg::CH_BSL);
			seq.push_back(rtfe_pkg::CH_U);
			foreach (digs[i]) begin
				seq.push_back(digs[i]);
			end
			seq.push_back(rtfe_pkg::CH_QMARK);
			dec_units++;
		end
		foreach (seq[i]) begin
			w.ch  = seq[i];
			w.fin = (i == seq.size() - 1);
			expected_words.push_back(w);
		end
	endtask

	task automatic note_mismatch(input string what, input esc_word_t want);
		fails++;
		if (fails <= REPORT_MAX) begin
			$display("%0t mismatch (%s): expected byte %02h last %0b, got byte %02h last %0b",
				$realtime, what, want.ch, want.fin, out_byte, last);
		end
	endtask

	// compare output words against the oldest expectation, then predict new input
	always @(posedge clk) begin
		esc_word_t want;
		if (arst_n) begin
			if (esc_valid && esc_ready) begin
				words++;
				if (expected_words.size() == 0) begin
					want = '0;
					note_mismatch("word with nothing expected", want);
				end else begin
					want = expected_words.pop_front();
					if (want.ch !== out_byte) begin
						note_mismatch("out_byte", want);
					end else if (want.fin !== last) begin
						note_mismatch("last", want);
					end
				end
			end
			if (code_valid && code_ready) begin
				units++;
				queue_escape(code_unit);
			end
			pending = expected_words.size();
		end
	end

endmodule

@@ dv/rtf_text_escaper_tb.sv @@
`timescale 1ns / 1ps
// rtf_text_escaper_tb: stimulus, handshake pacing, watchdog and verdict for the escaper

module rtf_text_escaper_tb;

	localparam int CODE_W       = rtfe_pkg::CODE_W;
	localparam int RANDOM_UNITS = 400;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 24;
	localparam int N_CORNERS    = 23;

	// zero, class boundaries, escaped punctuation, digit-count steps, wide bit patterns
	localparam logic [CODE_W-1:0] CORNER_CODES [N_CORNERS] = '{
		16'h0000, 16'd1, 16'd9, 16'd31, 16'd32, 16'h0041, 16'd127, 16'd128,
		16'd200, 16'd255, 16'h005C, 16'h007B, 16'h007D, 16'd256, 16'd999,
		16'd1000, 16'd9999, 16'd10000, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA,
		16'h7FFF
	};

	logic clk;
	logic arst_n;
	logic steady;
	int   fails;
	int   pending;
	int   units;
	int   words;
	int   hex_units;
	int   dec_units;
	int   quiet_cycles;

	rtfe_code_if code_ch ();
	rtfe_byte_if esc_ch ();

	rtf_text_escaper DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.code    (code_ch),
		.escaped (esc_ch)
	);

	rtf_text_escaper_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_ch.valid),
		.code_ready (code_ch.ready),
		.code_unit  (code_ch.code_unit),
		.esc_valid  (esc_ch.valid),
		.esc_ready  (esc_ch.ready),
		.out_byte   (esc_ch.out_byte),
		.last       (esc_ch.last),
		.fails      (fails),
		.pending    (pending),
		.units      (units),
		.words      (words),
		.hex_units  (hex_units),
		.dec_units  (dec_units)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver back-pressure, off during the steady stretch
	always @(negedge clk) begin
		esc_ch.ready <= steady || ($urandom_range(99) >= 32);
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((code_ch.valid && code_ch.ready) || (esc_ch.valid && esc_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("no handshake for %0d cycles", STALL_LIMIT);
			$display("rtf_text_escaper regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// random code unit, weighted over the escape classes
	function automatic logic [CODE_W-1:0] pick_code();
		int k;
		k = $urandom_range(99);
		if (k < 30) begin
			return CODE_W'($urandom_range(127, 32));
		end else if (k < 40) begin
			case ($urandom_range(2))
				0: return CODE_W'(rtfe_pkg::CH_BSL);
				1: return CODE_W'(rtfe_pkg::CH_LBRACE);
				default: return CODE_W'(rtfe_pkg::CH_RBRACE);
			endcase
		end else if (k < 55) begin
			return CODE_W'($urandom_range(31, 0));
		end else if (k < 62) begin
			return CODE_W'($urandom_range(255, 128));
		end else if (k < 72) begin
			return CODE_W'($urandom_range(999, 256));
		end else if (k < 82) begin
			return CODE_W'($urandom_range(9999, 1000));
		end
		return CODE_W'($urandom_range(65535, 10000));
	endfunction

	// offer one code unit from a falling edge, return at the falling edge after acceptance
	task automatic send_code(input logic [CODE_W-1:0] c);
		while (!steady && $urandom_range(99) < 32) begin
			code_ch.valid <= 1'b0;
			@(negedge clk);
		end
		code_ch.valid     <= 1'b1;
		code_ch.code_unit <= c;
		@(posedge clk);
		while (!code_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	initial begin
		arst_n            = 1'b0;
		steady            = 1'b0;
		quiet_cycles      = 0;
		code_ch.valid     = 1'b0;
		code_ch.code_unit = '0;
		esc_ch.ready      = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners
		foreach (CORNER_CODES[i]) begin
			send_code(CORNER_CODES[i]);
		end

		// random stream with a stretch of full throughput in the middle
		for (int n = 0; n < RANDOM_UNITS; n++) begin
			steady = (n >= 150 && n < 250);
			send_code(pick_code());
		end
		steady = 1'b0;
		code_ch.valid <= 1'b0;

		// drain
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d code units: %0d hex escapes, %0d decimal escapes; checked %0d words",
			units, hex_units, dec_units, words);
		$display("corners plus a weighted random stream, stalls on both sides and one steady run");
		if (fails == 0 && pending == 0) begin
			$display("rtf_text_escaper regression: pass");
		end else begin
			$display("%0d mismatches, %0d words still expected", fails, pending);
			$display("rtf_text_escaper regression: fail");
		end
		$finish;
	end

endmodule
